### sv/vn2o_pkg.sv
package vn2o_pkg;

   localparam int PRIME_SETS = 10;
   localparam int MAX_OCTAVES = 8;
   localparam int BLEND_DEPTH = 1024;
   localparam int BLEND_AW = $clog2(BLEND_DEPTH);
   localparam int BASE_SETS = 10;

   localparam int OCT_W = 4;
   localparam int PERS_W = 17;
   localparam int SET_W = 4;
   localparam int COORD_W = 32;
   localparam int NOISE_W = 32;
   localparam int HASH_W = 31;
   localparam int SHIFT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int SMOOTH_W = 37;
   localparam int BLEND_W = 17;

   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [1:0] CSR_PERSISTENCE = 2'd1;
   localparam logic [1:0] CSR_FIRST_SET = 2'd2;

   localparam logic [HASH_W-1:0] HASH_PRIMES [BASE_SETS*3] = '{
      31'd995615039, 31'd600173719, 31'd701464987,
      31'd831731269, 31'd162318869, 31'd136250887,
      31'd174329291, 31'd946737083, 31'd245679977,
      31'd362489573, 31'd795918041, 31'd350777237,
      31'd457025711, 31'd880830799, 31'd909678923,
      31'd787070341, 31'd177340217, 31'd593320781,
      31'd405493717, 31'd291031019, 31'd391950901,
      31'd458904767, 31'd676625681, 31'd424452397,
      31'd531736441, 31'd939683957, 31'd810651871,
      31'd997169939, 31'd842027887, 31'd423882827
   };

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   typedef logic [BLEND_W-1:0] blend_rom_type [BLEND_DEPTH];

   typedef struct packed {
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      logic [HASH_W-1:0] c;
   } coef_type;

   // per octave word traveling beside the datapath
   typedef struct packed {
      logic                valid;
      logic                live;
      logic                first;
      logic                last;
      logic [PERS_W-1:0]   amp;
      logic [BLEND_AW-1:0] fx_idx;
      logic [BLEND_AW-1:0] fy_idx;
      coef_type            coef;
   } tok_type;

   // round(65536 * sin^2) via sine polynomial in q2.30
   function automatic logic [BLEND_W-1:0] blend_low(input longint unsigned k);
      longint unsigned u;
      longint unsigned w;
      longint unsigned r;
      longint unsigned s;
      longint unsigned f;
      u = (PI_HALF_Q30 * k) / BLEND_DEPTH;
      w = (u * u) >> 30;
      r = ONE_Q30;
      r = ONE_Q30 - ((w * r) >> 30) / 110;
      r = ONE_Q30 - ((w * r) >> 30) / 72;
      r = ONE_Q30 - ((w * r) >> 30) / 42;
      r = ONE_Q30 - ((w * r) >> 30) / 20;
      r = ONE_Q30 - ((w * r) >> 30) / 6;
      s = (u * r) >> 30;
      f = (s * s) >> 30;
      return BLEND_W'((f + 64'd8192) >> 14);
   endfunction

   function automatic blend_rom_type build_blend_rom();
      blend_rom_type rom;
      for (int k = 0; k < BLEND_DEPTH; k++) begin
         if (2 * k <= BLEND_DEPTH) begin
            rom[k] = blend_low(64'(k));
         end else begin
            rom[k] = BLEND_W'(65536) - blend_low(64'(BLEND_DEPTH - k));
         end
      end
      return rom;
   endfunction

   localparam blend_rom_type BLEND_ROM = build_blend_rom();

   function automatic coef_type hash_coef(input logic [SET_W-1:0] set_idx);
      coef_type cf;
      logic [SET_W-1:0] base_set;
      logic [4:0] base;
      base_set = set_idx;
      if (base_set >= SET_W'(BASE_SETS)) begin
         base_set = base_set - SET_W'(BASE_SETS);
      end
      base = 5'(base_set) * 5'd3;
      cf.a = HASH_PRIMES[base];
      cf.b = HASH_PRIMES[base + 5'd1];
      cf.c = HASH_PRIMES[base + 5'd2];
      return cf;
   endfunction

endpackage

### sv/vn2o_hash_cell.sv
module vn2o_hash_cell (
   input  logic                             clock,
   input  logic [vn2o_pkg::COORD_W-1:0]     x_pt,
   input  logic [vn2o_pkg::COORD_W-1:0]     y_pt,
   input  logic [vn2o_pkg::HASH_W-1:0]      mul_a,
   input  logic [vn2o_pkg::HASH_W-1:0]      add_b,
   input  logic [vn2o_pkg::HASH_W-1:0]      add_c,
   output logic [vn2o_pkg::HASH_W-1:0]      hash_out
);

   logic [vn2o_pkg::COORD_W-1:0] mix;
   logic [vn2o_pkg::HASH_W-1:0] n_in;
   logic [vn2o_pkg::HASH_W-1:0] n_s1_ff;
   logic [vn2o_pkg::HASH_W-1:0] n_s2_ff;
   logic [vn2o_pkg::HASH_W-1:0] sq_s2_ff;
   logic [vn2o_pkg::HASH_W-1:0] n_s3_ff;
   logic [vn2o_pkg::HASH_W-1:0] m_s3_ff;
   logic [vn2o_pkg::HASH_W-1:0] t_s4_ff;

   // only the low 31 bits survive the final mask, so all math after the coordinate mix runs at 31 bits
   assign mix = x_pt + y_pt * 32'd57;
   assign n_in = vn2o_pkg::HASH_W'((mix << 13) ^ mix);

   always_ff @(posedge clock) begin
      n_s1_ff <= n_in;
      n_s2_ff <= n_s1_ff;
      sq_s2_ff <= vn2o_pkg::HASH_W'(n_s1_ff * n_s1_ff);
      n_s3_ff <= n_s2_ff;
      m_s3_ff <= vn2o_pkg::HASH_W'(sq_s2_ff * mul_a + add_b);
      t_s4_ff <= vn2o_pkg::HASH_W'(n_s3_ff * m_s3_ff + add_c);
   end

   assign hash_out = t_s4_ff;

endmodule

### sv/vn2o_blend_cell.sv
module vn2o_blend_cell (
   input  logic                                    clock,
   input  logic signed [vn2o_pkg::SMOOTH_W-1:0]    lo_val,
   input  logic signed [vn2o_pkg::SMOOTH_W-1:0]    hi_val,
   input  logic [vn2o_pkg::BLEND_W-1:0]            weight,
   output logic signed [vn2o_pkg::SMOOTH_W-1:0]    blend_out
);

   localparam int DIFF_W = vn2o_pkg::SMOOTH_W + 1;
   localparam int PROD_W = DIFF_W + vn2o_pkg::BLEND_W + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [vn2o_pkg::SMOOTH_W-1:0] lo_ff;
   logic signed [vn2o_pkg::SMOOTH_W-1:0] out_ff;

   assign diff = DIFF_W'(hi_val) - DIFF_W'(lo_val);
   // floor of (prod + half) / 65536
   assign rnd = (prod_ff + PROD_W'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));
      lo_ff <= lo_val;
      out_ff <= lo_ff + vn2o_pkg::SMOOTH_W'(rnd);
   end

   assign blend_out = out_ff;

endmodule

### sv/vn2o_blend_rom.sv
module vn2o_blend_rom (
   input  logic                            clock,
   input  logic [vn2o_pkg::BLEND_AW-1:0]   addr_a,
   input  logic [vn2o_pkg::BLEND_AW-1:0]   addr_b,
   output logic [vn2o_pkg::BLEND_W-1:0]    data_a,
   output logic [vn2o_pkg::BLEND_W-1:0]    data_b
);

   logic [vn2o_pkg::BLEND_W-1:0] rd_a_ff;
   logic [vn2o_pkg::BLEND_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      rd_a_ff <= vn2o_pkg::BLEND_ROM[addr_a];
      rd_b_ff <= vn2o_pkg::BLEND_ROM[addr_b];
   end

   assign data_a = rd_a_ff;
   assign data_b = rd_b_ff;

endmodule

### sv/value_noise_2d_octaves_unit.sv
// fractal 2d value noise: q16.16 coordinate pair in, q7.24 noise word out.
// input: raise start with req_coord_x/req_coord_y; the word is taken at a
// clock edge where start is high and busy is low.
// config: csr_write_enable with csr_index (0 octave count, 1 persistence,
// 2 first prime set) and csr_write_data; write only while no sample is open.
// each sample is split into n octave passes (n = clamped octave count, at
// least one pass), one pass issued per cycle; a new sample is taken only once
// the last pass of the sample before has issued. the sixteen hash cells take
// one octave per cycle; the passes run down a 12 stage chain (hash, smooth,
// blend x, blend y, weight) into an accumulator.
// output: rsp_valid is high for one cycle with rsp_noise_value once the last
// pass of a sample is accumulated. the receiver cannot stall, so nothing waits.
// reset: synchronous, clears the sequencer, the chain's valid bits and the
// result strobe, and loads the register defaults (4 octaves, persistence
// one half, first prime set 0).
module value_noise_2d_octaves_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [vn2o_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [vn2o_pkg::COORD_W-1:0]   req_coord_y,
   output logic                                  rsp_valid,
   output logic signed [vn2o_pkg::NOISE_W-1:0]   rsp_noise_value,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [vn2o_pkg::PERS_W-1:0]           csr_write_data
);

   localparam int SB_DEPTH = 12;
   localparam int SMOOTH_W = vn2o_pkg::SMOOTH_W;
   localparam int WEIGHT_W = SMOOTH_W + vn2o_pkg::PERS_W + 1;
   localparam int ACC_W = WEIGHT_W + 4;
   localparam int OCT_W = vn2o_pkg::OCT_W;
   localparam int SET_W = vn2o_pkg::SET_W;
   localparam int PERS_W = vn2o_pkg::PERS_W;
   localparam int AW = vn2o_pkg::BLEND_AW;

   // configuration
   logic [OCT_W-1:0] oct_count_ff;
   logic [PERS_W-1:0] pers_ff;
   logic [SET_W-1:0] first_set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_count_ff <= OCT_W'(4);
         pers_ff <= PERS_W'(32768);
         first_set_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            vn2o_pkg::CSR_OCTAVE_COUNT: oct_count_ff <= csr_write_data[OCT_W-1:0];
            vn2o_pkg::CSR_PERSISTENCE: pers_ff <= csr_write_data;
            vn2o_pkg::CSR_FIRST_SET: first_set_ff <= csr_write_data[SET_W-1:0];
            default: ;
         endcase
      end
   end

   // octave sequencer
   logic busy_ff, busy_in;
   logic [OCT_W-1:0] cnt_ff, cnt_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [PERS_W-1:0] amp_ff, amp_in;
   logic signed [vn2o_pkg::COORD_W-1:0] cx_ff, cy_ff;

   logic accept, issue, last;
   logic [OCT_W-1:0] n_oct, oct_idx;
   logic [PERS_W-1:0] pers, amp_prev, amp_next;
   logic [2*PERS_W-1:0] amp_prod;
   logic [SET_W-1:0] set_sel, first_wrap;
   logic [vn2o_pkg::SHIFT_W-1:0] shift;
   logic signed [vn2o_pkg::COORD_W-1:0] src_x, src_y;
   logic [vn2o_pkg::COORD_W-1:0] mag_x, mag_y, mq_x, mq_y, ix_in, iy_in;
   logic [vn2o_pkg::COORD_W-1:0] ix_ff, iy_ff;
   vn2o_pkg::tok_type tok_in;
   vn2o_pkg::tok_type sb_ff [SB_DEPTH];

   assign accept = start && !busy_ff;
   assign issue = accept || busy_ff;
   assign n_oct = (oct_count_ff > OCT_W'(vn2o_pkg::MAX_OCTAVES))
                  ? OCT_W'(vn2o_pkg::MAX_OCTAVES) : oct_count_ff;
   assign pers = (pers_ff > PERS_W'(65536)) ? PERS_W'(65536) : pers_ff;
   assign first_wrap = (first_set_ff >= SET_W'(vn2o_pkg::PRIME_SETS))
                       ? first_set_ff - SET_W'(vn2o_pkg::PRIME_SETS) : first_set_ff;

   assign src_x = accept ? req_coord_x : cx_ff;
   assign src_y = accept ? req_coord_y : cy_ff;
   assign oct_idx = accept ? '0 : cnt_ff;
   assign set_sel = accept ? first_wrap : set_ff;
   assign amp_prev = accept ? PERS_W'(65536) : amp_ff;
   assign amp_prod = (2*PERS_W)'(amp_prev) * (2*PERS_W)'(pers);
   assign amp_next = PERS_W'((amp_prod + (2*PERS_W)'(32768)) >> 16);
   assign last = (n_oct == '0) || (oct_idx == n_oct - OCT_W'(1));
   assign shift = vn2o_pkg::SHIFT_W'(n_oct - OCT_W'(1) - oct_idx);

   // truncate toward zero: shift the magnitude, put the sign back on the integer
   assign mag_x = src_x[vn2o_pkg::COORD_W-1] ? vn2o_pkg::COORD_W'(-src_x) : src_x;
   assign mag_y = src_y[vn2o_pkg::COORD_W-1] ? vn2o_pkg::COORD_W'(-src_y) : src_y;
   assign mq_x = mag_x >> shift;
   assign mq_y = mag_y >> shift;
   assign ix_in = src_x[vn2o_pkg::COORD_W-1] ? -{16'b0, mq_x[31:16]} : {16'b0, mq_x[31:16]};
   assign iy_in = src_y[vn2o_pkg::COORD_W-1] ? -{16'b0, mq_y[31:16]} : {16'b0, mq_y[31:16]};

   always_comb begin
      tok_in.valid = issue;
      tok_in.live = (n_oct != '0);
      tok_in.first = (oct_idx == '0);
      tok_in.last = last;
      tok_in.amp = amp_next;
      tok_in.fx_idx = mq_x[15 -: AW];
      tok_in.fy_idx = mq_y[15 -: AW];
      tok_in.coef = vn2o_pkg::hash_coef(set_sel);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      set_in = set_ff;
      amp_in = amp_ff;
      if (issue) begin
         busy_in = !last;
         cnt_in = oct_idx + OCT_W'(1);
         set_in = (set_sel == SET_W'(vn2o_pkg::PRIME_SETS - 1)) ? '0 : set_sel + SET_W'(1);
         amp_in = amp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         set_ff <= '0;
         amp_ff <= PERS_W'(65536);
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         set_ff <= set_in;
         amp_ff <= amp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
      end
      ix_ff <= ix_in;
      iy_ff <= iy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SB_DEPTH; k++) begin
            sb_ff[k].valid <= 1'b0;
         end
      end else begin
         sb_ff[0] <= tok_in;
         for (int k = 1; k < SB_DEPTH; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   assign busy = busy_ff;

   // 4x4 neighbourhood of hash cells, grid point (gx, gy) is (ix+gx-1, iy+gy-1)
   logic [vn2o_pkg::HASH_W-1:0] hash_t [16];
   logic signed [31:0] pv [16];

   for (genvar gy = 0; gy < 4; gy++) begin : g_row
      for (genvar gx = 0; gx < 4; gx++) begin : g_col
         vn2o_hash_cell u_hash (
            .clock    (clock),
            .x_pt     (ix_ff + 32'(gx - 1)),
            .y_pt     (iy_ff + 32'(gy - 1)),
            .mul_a    (sb_ff[2].coef.a),
            .add_b    (sb_ff[2].coef.b),
            .add_c    (sb_ff[3].coef.c),
            .hash_out (hash_t[gy*4+gx])
         );
         assign pv[gy*4+gx] = 32'sd1073741824 - $signed({1'b0, hash_t[gy*4+gx]});
      end
   end

   // smoothing of the four cell corners
   logic signed [33:0] corner_ff [4];
   logic signed [33:0] side_ff [4];
   logic signed [31:0] mid_ff [4];
   logic signed [SMOOTH_W-1:0] sm_ff [4];

   for (genvar c = 0; c < 4; c++) begin : g_smooth
      localparam int CX = c % 2;
      localparam int CY = c / 2;
      always_ff @(posedge clock) begin
         corner_ff[c] <= 34'(pv[CY*4+CX]) + 34'(pv[CY*4+CX+2])
                       + 34'(pv[(CY+2)*4+CX]) + 34'(pv[(CY+2)*4+CX+2]);
         side_ff[c] <= 34'(pv[CY*4+CX+1]) + 34'(pv[(CY+2)*4+CX+1])
                     + 34'(pv[(CY+1)*4+CX]) + 34'(pv[(CY+1)*4+CX+2]);
         mid_ff[c] <= pv[(CY+1)*4+CX+1];
         sm_ff[c] <= SMOOTH_W'(corner_ff[c]) + (SMOOTH_W'(side_ff[c]) <<< 1)
                   + (SMOOTH_W'(mid_ff[c]) <<< 2);
      end
   end

   // cosine weights, read one stage ahead of each blend
   logic [vn2o_pkg::BLEND_W-1:0] wx, wy;

   vn2o_blend_rom u_rom (
      .clock  (clock),
      .addr_a (sb_ff[5].fx_idx),
      .addr_b (sb_ff[7].fy_idx),
      .data_a (wx),
      .data_b (wy)
   );

   logic signed [SMOOTH_W-1:0] i1, i2, v_oct;

   vn2o_blend_cell u_blend_x0 (
      .clock (clock), .lo_val (sm_ff[0]), .hi_val (sm_ff[1]), .weight (wx), .blend_out (i1)
   );
   vn2o_blend_cell u_blend_x1 (
      .clock (clock), .lo_val (sm_ff[2]), .hi_val (sm_ff[3]), .weight (wx), .blend_out (i2)
   );
   vn2o_blend_cell u_blend_y (
      .clock (clock), .lo_val (i1), .hi_val (i2), .weight (wy), .blend_out (v_oct)
   );

   // octave weight and accumulate
   logic signed [WEIGHT_W-1:0] w_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_base, acc_sum, acc_rnd;
   logic rsp_valid_ff;
   logic signed [vn2o_pkg::NOISE_W-1:0] rsp_noise_ff;

   assign acc_base = sb_ff[11].first ? '0 : acc_ff;
   assign acc_sum = acc_base + (sb_ff[11].live ? ACC_W'(w_ff) : '0);
   assign acc_rnd = (acc_sum + ACC_W'(1 << 25)) >>> 26;

   always_ff @(posedge clock) begin
      w_ff <= WEIGHT_W'(v_oct) * WEIGHT_W'($signed({1'b0, sb_ff[10].amp}));
      if (sb_ff[11].valid) begin
         acc_ff <= acc_sum;
      end
      if (sb_ff[11].valid && sb_ff[11].last) begin
         rsp_noise_ff <= vn2o_pkg::NOISE_W'(acc_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sb_ff[11].valid && sb_ff[11].last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

endmodule
